[src/fps_pkg.sv]
// ============================================================================
// fps_pkg: shared constants for the Fenwick prefix sum table
// Table depth, pointer widths, payload widths and mode codes.
// ============================================================================
`default_nettype none

package fps_pkg;

  // number of cells, indexed 1..DEPTH (entry 0 unused)
  localparam int DEPTH   = 1024;
  // address width of the cell memory (entries 0..DEPTH)
  localparam int ADDR_W  = $clog2(DEPTH + 1);
  // payload widths
  localparam int MODE_W  = 2;
  localparam int POS_W   = 11;
  localparam int DELTA_W = 32;
  localparam int SUM_W   = 64;
  // walk pointer: holds any position and the overshoot of an upward walk
  localparam int PTR_W   = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANGE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POINT  = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [SUM_W-1:0] sum_t;

endpackage

`default_nettype wire

[src/fenwick_prefix_sum_table.sv]
// ============================================================================
// fenwick_prefix_sum_table: binary indexed tree with point add and range sum
// Cells live in one 1R1W memory with registered read data.
// ============================================================================
// One word in per handshake. Mode 0 adds a sign-extended delta at a
// one-based position and gives no output word; adds at position 0 or above
// DEPTH change nothing. Mode 1 gives the prefix sum up to position, mode 2
// the sum over range_start..position, mode 3 one position's value; query
// positions are clipped to DEPTH and a range start of 0 counts as 1. All
// sums wrap modulo 2^64. After reset the block clears the cell memory
// (entries 0..DEPTH) with in_ready low. An add reads, then writes back,
// each tree level it touches, one level after another. A query runs two
// downward walks with one memory read per cycle; the single memory read
// port sets this pace. One word is in work at a time; a finished result
// waits in an output register while the next word is taken.
`default_nettype none

module fenwick_prefix_sum_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [fps_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [fps_pkg::POS_W-1:0]   in_position,
  input  wire logic [fps_pkg::POS_W-1:0]   in_range_start,
  input  wire logic signed [fps_pkg::DELTA_W-1:0] in_delta,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [fps_pkg::SUM_W-1:0] out_sum
);

  // state codes
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ADD_RD = 3'd2;
  localparam logic [2:0] ST_ADD_WR = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  localparam fps_pkg::ptr_t DEPTH_P = fps_pkg::PTR_W'(fps_pkg::DEPTH);
  localparam fps_pkg::ptr_t ONE_P   = fps_pkg::PTR_W'(1);

  logic [2:0]                   state_r, state_nxt;
  logic [fps_pkg::ADDR_W-1:0]   clr_r, clr_nxt;
  fps_pkg::ptr_t                p_r, p_nxt;     // current walk pointer
  fps_pkg::ptr_t                b_r, b_nxt;     // start of second walk
  logic                         phase_r, phase_nxt; // 1: subtracting walk
  logic                         pend_r, pend_nxt;   // read data due
  logic                         neg_r, neg_nxt;     // sign for due data
  fps_pkg::sum_t                delta_r, delta_nxt;
  fps_pkg::sum_t                acc_r, acc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  fps_pkg::sum_t                out_sum_r, out_sum_nxt;

  // cell memory
  fps_pkg::sum_t                mem [0:fps_pkg::DEPTH];
  fps_pkg::sum_t                rdata_r;
  logic                         mem_we, mem_re;
  logic [fps_pkg::ADDR_W-1:0]   mem_waddr, mem_raddr;
  fps_pkg::sum_t                mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // clipped positions of the incoming word
  fps_pkg::ptr_t pos_ext, start_ext, pos_clip, start_fix, start_clip;
  fps_pkg::ptr_t p_lsb, p_up;

  always_comb begin
    pos_ext    = fps_pkg::PTR_W'(in_position);
    start_ext  = fps_pkg::PTR_W'(in_range_start);
    pos_clip   = (pos_ext > DEPTH_P) ? DEPTH_P : pos_ext;
    start_fix  = (start_ext == '0) ? ONE_P : start_ext;
    start_clip = (start_fix > DEPTH_P) ? DEPTH_P : start_fix;
    p_lsb      = p_r & (~p_r + ONE_P);
    p_up       = p_r + p_lsb;
  end

  // control and datapath next state
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    p_nxt         = p_r;
    b_nxt         = b_r;
    phase_nxt     = phase_r;
    pend_nxt      = 1'b0;
    neg_nxt       = neg_r;
    delta_nxt     = delta_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = p_r[fps_pkg::ADDR_W-1:0];
    mem_raddr     = p_r[fps_pkg::ADDR_W-1:0];
    mem_wdata     = rdata_r + delta_r;
    in_ready      = 1'b0;

    // output register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // fold in read data from the previous cycle's walk step
    if (pend_r) begin
      acc_nxt = neg_r ? (acc_r - rdata_r) : (acc_r + rdata_r);
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == fps_pkg::ADDR_W'(fps_pkg::DEPTH)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          delta_nxt = fps_pkg::SUM_W'(in_delta);
          phase_nxt = 1'b0;
          acc_nxt   = '0;
          if (in_mode == fps_pkg::MODE_ADD) begin
            p_nxt = pos_ext;
            if (pos_ext != '0 && pos_ext <= DEPTH_P) begin
              state_nxt = ST_ADD_RD;
            end
          end else begin
            p_nxt     = pos_clip;
            state_nxt = ST_WALK;
            if (in_mode == fps_pkg::MODE_PREFIX) begin
              b_nxt = '0;
            end else if (in_mode == fps_pkg::MODE_RANGE) begin
              b_nxt = start_clip - ONE_P;
            end else begin
              b_nxt = (pos_clip == '0) ? '0 : (pos_clip - ONE_P);
            end
          end
        end
      end
      ST_ADD_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        mem_we = 1'b1;
        p_nxt  = p_up;
        state_nxt = (p_up > DEPTH_P) ? ST_IDLE : ST_ADD_RD;
      end
      ST_WALK: begin
        if (p_r != '0) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          neg_nxt  = phase_r;
          p_nxt    = p_r & (p_r - ONE_P);
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
          p_nxt     = b_r;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    b_r       <= b_nxt;
    neg_r     <= neg_nxt;
    delta_r   <= delta_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;

endmodule

`default_nettype wire

[tb/sv/tb_fenwick_prefix_sum_table.sv]
// ============================================================================
// tb_fenwick_prefix_sum_table: self-checking bench for the Fenwick sum table
// A queue of words drives the input channel; each accepted add updates a
// local copy of the tree and each accepted query queues the sum it must
// return. Output words are checked in order against that queue under random
// sender gaps and receiver stalls.
// ============================================================================

module tb_fenwick_prefix_sum_table;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DEPTH      = fps_pkg::DEPTH;
  localparam int  POS_MAX    = (1 << fps_pkg::POS_W) - 1;
  localparam int  TAIL       = 60;
  localparam int  CYCLE_CAP  = 400000;
  localparam int  RAND_WORDS = 1230;
  localparam int  CALM_WORDS = 150;

  typedef enum logic [fps_pkg::MODE_W-1:0] {
    MODE_ADD    = fps_pkg::MODE_ADD,
    MODE_PREFIX = fps_pkg::MODE_PREFIX,
    MODE_RANGE  = fps_pkg::MODE_RANGE,
    MODE_POINT  = fps_pkg::MODE_POINT
  } op_e;

  typedef struct {
    op_e                        op;
    logic [fps_pkg::POS_W-1:0]  position;
    logic [fps_pkg::POS_W-1:0]  range_start;
    logic [fps_pkg::DELTA_W-1:0] delta;
    bit                         drain_first;  // hold off until all sums are back
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [fps_pkg::MODE_W-1:0] in_mode = '0;
  logic [fps_pkg::POS_W-1:0] in_position = '0;
  logic [fps_pkg::POS_W-1:0] in_range_start = '0;
  logic signed [fps_pkg::DELTA_W-1:0] in_delta = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [fps_pkg::SUM_W-1:0] out_sum;

  // words waiting to be sent, sums waiting to come back
  word_t pending_words[$];
  fps_pkg::sum_t expected_sums[$];
  // local copy of the tree
  fps_pkg::sum_t cells [0:DEPTH];

  int send_pct = 0;
  int recv_pct = 0;
  bit calm = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  int words_taken = 0;
  int sums_checked = 0;
  int sum_mismatches = 0;
  int stray_words = 0;
  int mode_count [4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  fenwick_prefix_sum_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_range_start (in_range_start),
    .in_delta       (in_delta),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sum        (out_sum)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tree model
  // ---------------------------------------------------------------------------
  function automatic int unsigned clip_to_depth(input int unsigned p);
    return (p > DEPTH) ? DEPTH : p;
  endfunction

  function automatic fps_pkg::sum_t prefix_upto(input int unsigned p);
    fps_pkg::sum_t acc;
    int unsigned   k;
    acc = '0;
    k = clip_to_depth(p);
    while (k != 0) begin
      acc += cells[k];
      k = k & (k - 1);
    end
    return acc;
  endfunction

  function automatic void add_into_tree(input int unsigned p, input fps_pkg::sum_t amt);
    int unsigned k;
    k = p;
    if (k == 0 || k > DEPTH) return;
    while (k <= DEPTH) begin
      cells[k] += amt;
      k += k & (~k + 1);
    end
  endfunction

  // apply one accepted word; queries queue the sum they must return
  function automatic void apply_word(input word_t w);
    int unsigned   last;
    int unsigned   first;
    fps_pkg::sum_t s;
    last = clip_to_depth(w.position);
    first = (w.range_start == 0) ? 1 : clip_to_depth(w.range_start);
    mode_count[w.op]++;
    case (w.op)
      MODE_ADD: begin
        add_into_tree(w.position, {{32{w.delta[31]}}, w.delta});
      end
      MODE_PREFIX: begin
        expected_sums.push_back(prefix_upto(last));
      end
      MODE_RANGE: begin
        expected_sums.push_back(prefix_upto(last) - prefix_upto(first - 1));
      end
      default: begin
        s = (last == 0) ? '0 : prefix_upto(last) - prefix_upto(last - 1);
        expected_sums.push_back(s);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_word(input op_e op, input int unsigned pos,
                                     input int unsigned start, input logic [31:0] d,
                                     input bit drain);
    word_t w;
    w.op = op;
    w.position = fps_pkg::POS_W'(pos);
    w.range_start = fps_pkg::POS_W'(start);
    w.delta = d;
    w.drain_first = drain;
    pending_words.push_back(w);
  endfunction

  function automatic int unsigned rand_pos();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(DEPTH, 1);
    if (r < 87) begin
      case ($urandom_range(4))
        0: return 0;
        1: return 1;
        2: return 2;
        3: return DEPTH - 1;
        default: return DEPTH;
      endcase
    end
    return $urandom_range(POS_MAX, DEPTH + 1);
  endfunction

  function automatic logic [31:0] rand_delta();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4, 5: return $urandom;
      default: return 32'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic op_e rand_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return MODE_ADD;
    if (r < 60) return MODE_PREFIX;
    if (r < 80) return MODE_RANGE;
    return MODE_POINT;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: sends queued words, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    word_t w;
    logic  busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        w.op = op_e'(in_mode);
        w.position = in_position;
        w.range_start = in_range_start;
        w.delta = in_delta;
        apply_word(w);
        words_taken++;
        busy = 1'b0;
        if (!calm && $urandom_range(99) < send_pct) send_gap = $urandom_range(18, 1);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain_first && expected_sums.size() > 0)) begin
          w = pending_words.pop_front();
          in_mode <= w.op;
          in_position <= w.position;
          in_range_start <= w.range_start;
          in_delta <= w.delta;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls, in-order sum check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fps_pkg::sum_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          stray_words++;
          if (stray_words + sum_mismatches <= 10)
            $display("unexpected output word: sum=%0d (0x%016h)", out_sum, out_sum);
        end else begin
          want = expected_sums.pop_front();
          sums_checked++;
          if (out_sum !== want) begin
            sum_mismatches++;
            if (stray_words + sum_mismatches <= 10)
              $display("sum mismatch on word %0d: expected %0d (0x%016h) got %0d (0x%016h)",
                       sums_checked, $signed(want), want, out_sum, out_sum);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < recv_pct) begin
        recv_stall = $urandom_range(18, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    for (int i = 0; i <= DEPTH; i++) cells[i] = '0;

    // directed: empty tree, edge positions, ignored adds, clipping, odd ranges
    queue_word(MODE_PREFIX, 0, 0, 32'h0, 1'b0);
    queue_word(MODE_POINT, 0, 0, 32'h0, 1'b0);
    queue_word(MODE_ADD, 1, 0, 32'h7fff_ffff, 1'b0);
    queue_word(MODE_ADD, DEPTH, 0, 32'h8000_0000, 1'b0);
    queue_word(MODE_ADD, 0, 0, 32'h1234_5678, 1'b0);
    queue_word(MODE_ADD, DEPTH + 1, 0, 32'hffff_ffff, 1'b0);
    queue_word(MODE_ADD, POS_MAX, POS_MAX, 32'hffff_ffff, 1'b0);
    queue_word(MODE_ADD, 512, 0, 32'hffff_ffff, 1'b0);
    queue_word(MODE_ADD, 3, 0, 32'h0000_0005, 1'b0);
    queue_word(MODE_PREFIX, 1, 0, 32'h0, 1'b0);
    queue_word(MODE_PREFIX, DEPTH, 0, 32'h0, 1'b0);
    queue_word(MODE_PREFIX, POS_MAX, 0, 32'hffff_ffff, 1'b0);
    queue_word(MODE_RANGE, DEPTH, 0, 32'h0, 1'b0);
    queue_word(MODE_RANGE, POS_MAX, POS_MAX, 32'h0, 1'b0);
    queue_word(MODE_RANGE, 3, 1000, 32'h0, 1'b0);
    queue_word(MODE_RANGE, 1, 1, 32'h0, 1'b0);
    queue_word(MODE_RANGE, 0, 0, 32'h0, 1'b0);
    queue_word(MODE_POINT, 1, 0, 32'h0, 1'b0);
    queue_word(MODE_POINT, DEPTH, 0, 32'h0, 1'b0);
    queue_word(MODE_POINT, POS_MAX, 0, 32'h0, 1'b0);
    queue_word(MODE_POINT, 512, 0, 32'h0, 1'b0);
    queue_word(MODE_POINT, 3, 0, 32'h0, 1'b0);

    // random part; a few words wait for the output side to drain first
    for (int i = 0; i < RAND_WORDS; i++)
      queue_word(rand_op(), rand_pos(), rand_pos(), rand_delta(),
                 (i == 0 || i == 400 || i == 900));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // idle rates change every hundred words, sometimes to none
    while (pending_words.size() > CALM_WORDS) begin
      case ($urandom_range(3))
        0: send_pct = 0;
        1: send_pct = 10;
        2: send_pct = 35;
        default: send_pct = 70;
      endcase
      case ($urandom_range(3))
        0: recv_pct = 0;
        1: recv_pct = 3;
        2: recv_pct = 10;
        default: recv_pct = 25;
      endcase
      target = words_taken + 100;
      while (words_taken < target && pending_words.size() > CALM_WORDS) @(posedge clk);
    end
    calm = 1'b1;

    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (expected_sums.size() > 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("covered %0d words: %0d adds, %0d prefix, %0d range, %0d point queries",
             words_taken, mode_count[MODE_ADD], mode_count[MODE_PREFIX],
             mode_count[MODE_RANGE], mode_count[MODE_POINT]);
    $display("checked %0d sums: %0d mismatches, %0d unexpected, %0d missing",
             sums_checked, sum_mismatches, stray_words, expected_sums.size());
    if (sum_mismatches == 0 && stray_words == 0 && expected_sums.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
src/fps_pkg.sv
src/fenwick_prefix_sum_table.sv
tb/sv/tb_fenwick_prefix_sum_table.sv
